FILE: rtl/kui_pkg.sv
// types and constants shared by the kernel upsampling interpolator files
`default_nettype none

package kui_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAPS,
		ST_WAIT
	} state_t;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_UPSAMPLE_FACTOR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH      = CFG_IDX_W'(1);

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_COEF   = 1'b1;

	localparam int FACTOR_W     = 5;
	localparam int HALF_W       = 2;
	localparam int COEF_INDEX_W = 7;
	localparam int COEF_W       = 16;
	localparam int MAX_FACTOR   = 16;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(4);
	localparam logic [HALF_W-1:0]   HALF_RESET   = HALF_W'(2);

	// output phase within the kernel support, up to 3 * 16
	localparam int U_W   = 6;
	// kernel tap index, up to 48 + 6 * 16
	localparam int IDX_W = 8;

	localparam int FRAC_BITS  = 14;
	localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

endpackage

`default_nettype wire

FILE: rtl/kernel_upsampling_interpolator_core.sv
// Integer-factor polyphase FIR upsampler: a coefficient request (tuser high) writes one entry
// of the kernel table; a sample request (tuser low) shifts the sample into the window and
// emits the outputs it completes, and a sample with tlast high flushes the rest of the stream,
// marking the very last output with tuser. Each output is built in one multiply-accumulate
// unit that walks the 2a+1 taps, one kernel table read per cycle. A sample request that
// yields outputs holds off new requests until its last output is emitted; a coefficient
// request or a sample that yields nothing leaves the block ready. The kernel table has no
// reset and must be written before it is read. The config port always accepts
// and should only be written while no request is in progress.
`default_nettype none

module kernel_upsampling_interpolator_core #(
	parameter int MAX_TAPS       = 128,
	parameter int MAX_HALF_WIDTH = 3,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [kui_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kui_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// sample, coef_index, coef_value, zero padding
	input  logic [((SAMPLE_BITS + kui_pkg::COEF_INDEX_W + kui_pkg::COEF_W + 7) / 8) * 8 - 1:0]
	                                              s_axis_tdata,
	input  logic                                  s_axis_tlast,
	// mode
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// value, zero padding
	output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic                                  m_axis_tlast,
	// end_of_stream
	output logic                                  m_axis_tuser
);

	import kui_pkg::*;

	localparam int M_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);
	localparam int D_W       = $clog2(WIN_DEPTH + 1);
	localparam int TAP_AW    = $clog2(MAX_TAPS);
	localparam int PROD_W    = SAMPLE_BITS + COEF_W;
	localparam int ACC_W     = PROD_W + D_W;

	logic [FACTOR_W-1:0] factor_q;
	logic [HALF_W-1:0]   half_q;
	logic [FACTOR_W-1:0] n_eff;
	logic [HALF_W-1:0]   a_eff;

	state_t state_q, state_d;

	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic [COEF_INDEX_W-1:0]       in_coef_index;
	logic [COEF_W-1:0]             in_coef_value;

	logic s_accept, sample_accept, coef_wr;
	logic m_ge_a, has_out;
	logic [U_W-1:0]   a_n, u_start, u_end;
	logic [IDX_W-1:0] top;
	logic [D_W-1:0]   dmax;

	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic                          last_q;
	logic [FACTOR_W-1:0]           n_q;
	logic [D_W-1:0]                m_q, dmax_q, d_q;
	logic [U_W-1:0]                u_q, u_end_q;
	logic [IDX_W-1:0]              top_q, idx_q;

	logic signed [SAMPLE_BITS-1:0] win_q [WIN_DEPTH];
	logic [D_W-1:0]                cnt_q;

	logic                          tap_issue, emit, run_end, out_free;
	logic                          win_upd, upd_last;
	logic signed [SAMPLE_BITS-1:0] upd_cur;
	logic                          tap_ok;
	logic signed [SAMPLE_BITS-1:0] tap_x;

	logic [COEF_W-1:0]             kern_rdata;
	logic                          v_s1, ok_s1, first_s1, end_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic                          v_s2, first_s2, end_s2;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_W-1:0]       acc_q, acc_base, rounded;
	logic                          done_q;
	logic                          fits;
	logic [SAMPLE_BITS-1:0]        sat_value;

	logic                   out_valid_q, out_last_q, out_eos_q;
	logic [SAMPLE_BITS-1:0] out_value_q;

	assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
	assign in_coef_index = s_axis_tdata[SAMPLE_BITS +: COEF_INDEX_W];
	assign in_coef_value = s_axis_tdata[SAMPLE_BITS + COEF_INDEX_W +: COEF_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			half_q   <= HALF_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_UPSAMPLE_FACTOR) begin
				factor_q <= cfg_data[FACTOR_W-1:0];
			end else if (cfg_index == REG_HALF_WIDTH) begin
				half_q <= cfg_data[HALF_W-1:0];
			end
		end
	end

	// clamped factor and half width
	always_comb begin
		if (factor_q == '0) begin
			n_eff = FACTOR_W'(1);
		end else if (32'(factor_q) > MAX_FACTOR) begin
			n_eff = FACTOR_W'(MAX_FACTOR);
		end else begin
			n_eff = factor_q;
		end
		if (half_q == '0) begin
			a_eff = HALF_W'(1);
		end else if (32'(half_q) > MAX_HALF_WIDTH) begin
			a_eff = HALF_W'(MAX_HALF_WIDTH);
		end else begin
			a_eff = half_q;
		end
	end

	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign sample_accept = s_accept && (s_axis_tuser == MODE_SAMPLE);
	assign coef_wr       = s_accept && (s_axis_tuser == MODE_COEF) && (32'(in_coef_index) < MAX_TAPS);

	assign m_ge_a  = 32'(cnt_q) >= 32'(a_eff);
	assign has_out = m_ge_a || s_axis_tlast;
	assign a_n     = U_W'(a_eff) * U_W'(n_eff);
	assign u_start = m_ge_a ? '0 : U_W'(a_eff - HALF_W'(cnt_q)) * U_W'(n_eff);
	assign u_end   = s_axis_tlast ? a_n : U_W'(n_eff) - U_W'(1);
	assign top     = IDX_W'({a_n, 1'b0});
	assign dmax    = D_W'({a_eff, 1'b0});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_accept && has_out) begin
					state_d = ST_TAPS;
				end
			end
			ST_TAPS: begin
				if (d_q == dmax_q) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (emit) begin
					state_d = run_end ? ST_IDLE : ST_TAPS;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		tap_issue     = (state_q == ST_TAPS);
		emit          = (state_q == ST_WAIT) && done_q && out_free;
		run_end       = emit && (u_q == u_end_q);
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request registers and tap sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q     <= '0;
			idx_q   <= '0;
			u_q     <= '0;
			u_end_q <= '0;
			dmax_q  <= '0;
			top_q   <= '0;
			m_q     <= '0;
			n_q     <= FACTOR_W'(1);
			last_q  <= 1'b0;
		end else if (sample_accept) begin
			d_q     <= '0;
			idx_q   <= IDX_W'(u_start);
			u_q     <= u_start;
			u_end_q <= u_end;
			dmax_q  <= dmax;
			top_q   <= top;
			m_q     <= cnt_q;
			n_q     <= n_eff;
			last_q  <= s_axis_tlast;
		end else if (tap_issue) begin
			d_q   <= d_q + D_W'(1);
			idx_q <= idx_q + IDX_W'(n_q);
		end else if (emit && !run_end) begin
			u_q   <= u_q + U_W'(1);
			d_q   <= '0;
			idx_q <= IDX_W'(u_q) + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (sample_accept) begin
			cur_q <= in_sample;
		end
	end

	// sample window and stream position
	assign win_upd  = (sample_accept && !has_out) || run_end;
	assign upd_last = run_end && last_q;
	assign upd_cur  = run_end ? cur_q : in_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
			cnt_q <= '0;
		end else if (win_upd) begin
			if (upd_last) begin
				for (int k = 0; k < WIN_DEPTH; k++) begin
					win_q[k] <= '0;
				end
				cnt_q <= '0;
			end else begin
				for (int k = WIN_DEPTH - 1; k > 0; k--) begin
					win_q[k] <= win_q[k-1];
				end
				win_q[0] <= upd_cur;
				if (32'(cnt_q) < WIN_DEPTH) begin
					cnt_q <= cnt_q + D_W'(1);
				end
			end
		end
	end

	// kernel table, reads and coefficient writes never overlap
	kui_ram #(
		.WIDTH(COEF_W),
		.DEPTH(MAX_TAPS)
	) u_kernel_ram (
		.clk  (clk),
		.we   (coef_wr),
		.waddr(TAP_AW'(in_coef_index)),
		.wdata(in_coef_value),
		.raddr(TAP_AW'(idx_q)),
		.rdata(kern_rdata)
	);

	assign tap_ok = (32'(d_q) <= 32'(m_q)) && (idx_q <= top_q) && (32'(idx_q) < MAX_TAPS);
	assign tap_x  = (d_q == '0) ? cur_q : win_q[WIN_AW'(d_q - D_W'(1))];

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= tap_issue;
			v_s2 <= v_s1;
			if (v_s2 && end_s2) begin
				done_q <= 1'b1;
			end else if (emit) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tap_issue) begin
			ok_s1    <= tap_ok;
			x_s1     <= tap_x;
			first_s1 <= (d_q == '0);
			end_s1   <= (d_q == dmax_q);
		end
		if (v_s1) begin
			if (ok_s1) begin
				prod_s2 <= x_s1 * $signed(kern_rdata);
			end else begin
				prod_s2 <= '0;
			end
			first_s2 <= first_s1;
			end_s2   <= end_s1;
		end
		if (v_s2) begin
			acc_q <= acc_base + ACC_W'(prod_s2);
		end
	end

	assign acc_base = first_s2 ? '0 : acc_q;

	// round half up and saturate
	assign rounded = (acc_q + ACC_W'(ROUND_HALF)) >>> FRAC_BITS;
	assign fits    = rounded[ACC_W-1:SAMPLE_BITS-1] ==
	                 {(ACC_W - SAMPLE_BITS + 1){rounded[ACC_W-1]}};
	assign sat_value = fits ? rounded[SAMPLE_BITS-1:0] :
	                   (rounded[ACC_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}} :
	                                       {1'b0, {(SAMPLE_BITS - 1){1'b1}}});

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= sat_value;
			out_last_q  <= (u_q == u_end_q);
			out_eos_q   <= last_q && (u_q == u_end_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_DATA_W'(out_value_q);
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_eos_q;

endmodule

`default_nettype wire

FILE: rtl/kui_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module kui_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/kui_checker.sv
// port-level checks for the kernel upsampling interpolator and their bind
`default_nettype none

module kui_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic s_axis_tlast,
	input wire logic s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tlast,
	input wire logic m_axis_tuser
);

	import kui_pkg::*;

	// end of stream only on the final output of a request
	a_eos_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("end of stream without last of run");

	// a coefficient request never occupies the block
	a_coef_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COEF) |=> s_axis_tready)
		else $error("ready dropped after coefficient request");

	// a final sample always flushes at least one output
	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_SAMPLE) && s_axis_tlast
		|=> !s_axis_tready)
		else $error("final sample did not start a flush");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tlast) &&
		$stable(m_axis_tuser))
		else $error("output request dropped or changed while stalled");

endmodule

bind kernel_upsampling_interpolator_core kui_checker u_kui_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

FILE: test/tb_top.sv
// self-checking testbench for the kernel upsampling interpolator core
`default_nettype none

module tb_top;
	import kui_pkg::*;

	localparam int SAMPLE_BITS       = 16;
	localparam int MAX_TAPS          = 128;
	localparam int MAX_HALF_WIDTH    = 3;
	localparam int WIN_DEPTH         = 2 * MAX_HALF_WIDTH;
	localparam int IN_W              = ((SAMPLE_BITS + COEF_INDEX_W + COEF_W + 7) / 8) * 8;
	localparam int OUT_W             = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int PHASES            = 3;
	localparam int SAMPLES_PER_PHASE = 10;
	localparam int SETTLE_CYCLES     = 32;
	localparam int CYCLE_LIMIT       = 2_000_000;
	localparam longint SAT_HI        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO        = -SAT_HI - 1;

	typedef struct packed {
		logic                          mode;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
		logic [COEF_INDEX_W-1:0]       coef_index;
		logic signed [COEF_W-1:0]      coef_value;
	} request_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          last_of_run;
		logic                          end_of_stream;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;

	request_t   pending_requests [$];
	reg_write_t pending_writes [$];
	result_t    expected_outputs [$];

	// mirror of the block state
	logic signed [COEF_W-1:0]      kern_taps [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] win_hist [WIN_DEPTH];
	int                            fill_count = 0;
	logic [FACTOR_W-1:0]           factor_reg = FACTOR_RESET;
	logic [HALF_W-1:0]             half_reg   = HALF_RESET;

	request_t   accepted_req;
	request_t   next_req;
	reg_write_t applied_write;
	reg_write_t next_write;
	result_t    wanted;

	int failures        = 0;
	int samples_seen    = 0;
	int coefs_seen      = 0;
	int outputs_checked = 0;
	int settings_run    = 0;
	int cycle_count     = 0;
	int calm_left       = 0;
	int send_gap        = 0;
	int recv_stall      = 0;

	kernel_upsampling_interpolator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int eff_factor(logic [FACTOR_W-1:0] f);
		if (f == 0)
			return 1;
		if (f > MAX_FACTOR)
			return MAX_FACTOR;
		return int'(f);
	endfunction

	function automatic int eff_half(logic [HALF_W-1:0] h);
		if (h == 0)
			return 1;
		if (h > MAX_HALF_WIDTH)
			return MAX_HALF_WIDTH;
		return int'(h);
	endfunction

	// one output at phase offset t from the current sample position
	function automatic logic signed [SAMPLE_BITS-1:0] tap_sum(int t, int m,
			logic signed [SAMPLE_BITS-1:0] cur, int n, int a);
		longint acc;
		longint x;
		longint v;
		int idx;
		acc = 0;
		for (int d = 0; d <= 2 * a; d++) begin
			if (d > m)
				break;
			x = (d == 0) ? cur : win_hist[d - 1];
			idx = t + (d + a) * n;
			if (idx < 0 || idx > 2 * a * n || idx >= MAX_TAPS)
				continue;
			acc += x * longint'(kern_taps[idx]);
		end
		v = (acc + ROUND_HALF) >>> FRAC_BITS;
		if (v > SAT_HI)
			v = SAT_HI;
		else if (v < SAT_LO)
			v = SAT_LO;
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic interpolate_request(request_t r);
		int n;
		int a;
		int m;
		int start;
		logic signed [SAMPLE_BITS-1:0] vals [$];
		result_t o;
		if (r.mode == MODE_COEF) begin
			kern_taps[r.coef_index] = r.coef_value;
			coefs_seen++;
			return;
		end
		samples_seen++;
		n = eff_factor(factor_reg);
		a = eff_half(half_reg);
		m = fill_count;
		if (m >= a)
			for (int t = -a * n; t < -a * n + n; t++)
				vals.push_back(tap_sum(t, m, r.sample, n, a));
		if (r.last) begin
			start = (m >= a) ? (-a * n + n) : (-m * n);
			for (int t = start; t <= 0; t++)
				vals.push_back(tap_sum(t, m, r.sample, n, a));
		end
		foreach (vals[i]) begin
			o.value = vals[i];
			o.last_of_run = (i == vals.size() - 1);
			o.end_of_stream = r.last && (i == vals.size() - 1);
			expected_outputs.push_back(o);
		end
		if (r.last) begin
			foreach (win_hist[k])
				win_hist[k] = '0;
			fill_count = 0;
		end else begin
			for (int k = WIN_DEPTH - 1; k > 0; k--)
				win_hist[k] = win_hist[k - 1];
			win_hist[0] = r.sample;
			if (fill_count < 65535)
				fill_count++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm_left > 0 || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_coef(int idx, int val);
		request_t r;
		r.mode = MODE_COEF;
		r.coef_index = COEF_INDEX_W'(idx);
		r.coef_value = COEF_W'(val);
		r.sample = SAMPLE_BITS'($urandom);
		r.last = 1'($urandom_range(0, 1));
		pending_requests.push_back(r);
	endtask

	task automatic add_sample(int s, bit last);
		request_t r;
		r.mode = MODE_SAMPLE;
		r.sample = SAMPLE_BITS'(s);
		r.last = last;
		r.coef_index = COEF_INDEX_W'($urandom);
		r.coef_value = COEF_W'($urandom);
		pending_requests.push_back(r);
	endtask

	// linear interpolation kernel with a little jitter on every tap
	task automatic load_kernel(int n, int a);
		int span;
		int v;
		span = a * n;
		for (int k = 0; k <= 2 * span; k++) begin
			v = 16384 * (span - ((k > span) ? k - span : span - k)) / span;
			v = v + $urandom_range(0, 255) - 128;
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			add_coef(k, v);
		end
	endtask

	function automatic int pick_sample();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return $urandom_range(0, 1) ? 32767 : -32768;
		if (r == 1)
			return $urandom_range(0, 64) - 32;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	task automatic add_random_streams(int a);
		int done;
		int len;
		int sel;
		bit open_end;
		done = 0;
		open_end = ($urandom_range(0, 2) == 0);
		while (done < SAMPLES_PER_PHASE) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				len = $urandom_range(1, 2 * a);
			else if (sel < 8)
				len = $urandom_range(2 * a + 1, 12);
			else
				len = $urandom_range(13, 30);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 11) == 0)
					add_coef($urandom_range(0, MAX_TAPS - 1),
						int'($urandom_range(0, 65535)) - 32768);
				add_sample(pick_sample(),
					(i == len - 1) && !(open_end && done + 1 >= SAMPLES_PER_PHASE));
				done++;
			end
		end
	endtask

	task automatic add_directed();
		add_coef(8, 32767);
		add_coef(0, -32768);
		// single-sample stream
		add_sample(32767, 1'b1);
		// stream shorter than the kernel support
		add_sample(-32768, 1'b0);
		add_sample(0, 1'b1);
		// saturation both ways
		add_sample(32767, 1'b0);
		add_sample(32767, 1'b0);
		add_sample(32767, 1'b0);
		add_sample(-32768, 1'b0);
		add_sample(-32768, 1'b0);
		add_sample(-1, 1'b0);
		add_sample(1, 1'b1);
		add_coef(8, 16384);
		add_coef(0, 0);
		add_sample(12345, 1'b0);
		add_sample(-12345, 1'b0);
		add_sample(0, 1'b0);
		add_sample(-32768, 1'b1);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_requests.size() != 0 || expected_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_output();
		if (expected_outputs.size() == 0) begin
			$error("output with no request behind it: value %0d",
				$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
			failures++;
		end else begin
			wanted = expected_outputs.pop_front();
			outputs_checked++;
			if (m_axis_tdata[SAMPLE_BITS-1:0] !== wanted.value) begin
				$error("value mismatch: expected %0d, got %0d", wanted.value,
					$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
				failures++;
			end
			if (m_axis_tlast !== wanted.last_of_run) begin
				$error("last_of_run mismatch: expected %0b, got %0b",
					wanted.last_of_run, m_axis_tlast);
				failures++;
			end
			if (m_axis_tuser !== wanted.end_of_stream) begin
				$error("end_of_stream mismatch: expected %0b, got %0b",
					wanted.end_of_stream, m_axis_tuser);
				failures++;
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				accepted_req = pending_requests.pop_front();
				interpolate_request(accepted_req);
				send_gap = pick_gap();
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0 || pending_requests.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					s_axis_tvalid <= 1'b0;
				end else begin
					next_req = pending_requests[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {1'b0, next_req.coef_value, next_req.coef_index,
						next_req.sample};
					s_axis_tlast <= next_req.last;
					s_axis_tuser <= next_req.mode;
				end
			end
		end
	end

	// register write driver
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				applied_write = pending_writes.pop_front();
				if (applied_write.index == REG_UPSAMPLE_FACTOR)
					factor_reg = applied_write.data[FACTOR_W-1:0];
				else if (applied_write.index == REG_HALF_WIDTH)
					half_reg = applied_write.data[HALF_W-1:0];
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					next_write = pending_writes[0];
					cfg_valid <= 1'b1;
					cfg_index <= next_write.index;
					cfg_data <= next_write.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_output();
				recv_stall = pick_gap();
			end else if (recv_stall == 0 && $urandom_range(0, 15) == 0) begin
				recv_stall = pick_gap();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// cycle limit and stretches without idling
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (calm_left > 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 399) == 0)
			calm_left <= $urandom_range(50, 200);
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timed out after %0d cycles", cycle_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] fdat;
		logic [CFG_DATA_W-1:0] hdat;
		reg_write_t w;
		foreach (kern_taps[k])
			kern_taps[k] = '0;
		foreach (win_hist[k])
			win_hist[k] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				case (p)
					1: begin
						fdat = 8'hE0;
						hdat = 8'hFC;
					end
					2: begin
						fdat = 8'hFF;
						hdat = 8'hFF;
					end
					default: begin
						fdat = CFG_DATA_W'($urandom_range(0, 255));
						hdat = CFG_DATA_W'($urandom_range(0, 255));
					end
				endcase
				// unmapped index, must be ignored
				w.index = CFG_IDX_W'($urandom_range(2, 255));
				w.data = CFG_DATA_W'($urandom_range(0, 255));
				pending_writes.push_back(w);
				w.index = REG_UPSAMPLE_FACTOR;
				w.data = fdat;
				pending_writes.push_back(w);
				w.index = REG_HALF_WIDTH;
				w.data = hdat;
				pending_writes.push_back(w);
				while (pending_writes.size() != 0)
					@(posedge clk);
			end
			load_kernel(eff_factor(factor_reg), eff_half(half_reg));
			if (p == 0)
				add_directed();
			add_random_streams(eff_half(half_reg));
			settings_run++;
		end
		wait_idle();
		if (expected_outputs.size() != 0) begin
			$error("%0d outputs never arrived", expected_outputs.size());
			failures++;
		end
		$display("checked %0d outputs from %0d sample and %0d coefficient requests",
			outputs_checked, samples_seen, coefs_seen);
		$display("%0d factor/half-width settings, short, long and open streams, random gaps",
			settings_run);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
